// ===== rtl/go_to_goal_velocity_controller_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller: assertion macros
// Shared property wrappers clocked on the block clock, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_UNIT_DEFINES_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication
`define GGVC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define GGVC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ggvc_pkg.sv =====
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller package
// Widths, constants, the arctangent table and shared types.
// ----------------------------------------------------------------------------
package ggvc_pkg;

   localparam int CORDIC_STAGES = 14;
   localparam int ANG_TABLE_LEN = 24;
   localparam int NUM_CELLS     = (CORDIC_STAGES < ANG_TABLE_LEN) ? CORDIC_STAGES
                                                                  : ANG_TABLE_LEN;

   localparam int POS_W  = 16;   // positions, Q5.11
   localparam int HD_W   = 14;   // heading, Q3.11
   localparam int VAL_W  = 15;   // unsigned registers and outputs
   localparam int XY_W   = 24;   // CORDIC x and y, Q.15
   localparam int Z_W    = 24;   // angle accumulator, Q.20
   localparam int IDX_W  = 5;    // stage index
   localparam int CSR_W  = 3;
   localparam int MAG_W  = XY_W - 1;
   localparam int KP_W   = MAG_W + 16;   // x times 1/K
   localparam int DIST_W = 17;
   localparam int GP_W   = VAL_W + DIST_W;
   localparam int ERR_W  = Z_W + 2;

   localparam logic signed [Z_W-1:0] PI_Q20    = Z_W'(3294199);
   localparam logic        [15:0]    INV_K_Q16 = 16'd39797;

   localparam logic signed [POS_W-1:0] RST_TARGET_X  = 16'sd2048;
   localparam logic signed [POS_W-1:0] RST_TARGET_Y  = 16'sd2048;
   localparam logic        [VAL_W-1:0] RST_GAIN      = 15'd2048;
   localparam logic        [VAL_W-1:0] RST_MAX_SPEED = 15'd4096;
   localparam logic        [VAL_W-1:0] RST_DIST_THR  = 15'd205;
   localparam logic        [VAL_W-1:0] RST_ANG_THR   = 15'd410;

   typedef enum logic [CSR_W-1:0] {
      CSR_TARGET_X  = 3'd0,
      CSR_TARGET_Y  = 3'd1,
      CSR_GAIN      = 3'd2,
      CSR_MAX_SPEED = 3'd3,
      CSR_DIST_THR  = 3'd4,
      CSR_ANG_THR   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                     valid;
      logic signed [XY_W-1:0]   x;
      logic signed [XY_W-1:0]   y;
      logic signed [Z_W-1:0]    z;
      logic signed [HD_W-1:0]   hd;
   } cordic_type;

   typedef struct packed {
      logic        [VAL_W-1:0]  gain;
      logic        [VAL_W-1:0]  max_speed;
      logic        [VAL_W-1:0]  dist_thr;
      logic        [VAL_W-1:0]  ang_thr;
   } cfg_type;

   // atan(2^-i) in Q.20, rounded to nearest
   function automatic logic signed [Z_W-1:0] atan_q20(input logic [IDX_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:    v = Z_W'(823550);
         5'd1:    v = Z_W'(486170);
         5'd2:    v = Z_W'(256879);
         5'd3:    v = Z_W'(130396);
         5'd4:    v = Z_W'(65451);
         5'd5:    v = Z_W'(32757);
         5'd6:    v = Z_W'(16383);
         5'd7:    v = Z_W'(8192);
         5'd8:    v = Z_W'(4096);
         5'd9:    v = Z_W'(2048);
         5'd10:   v = Z_W'(1024);
         5'd11:   v = Z_W'(512);
         5'd12:   v = Z_W'(256);
         5'd13:   v = Z_W'(128);
         5'd14:   v = Z_W'(64);
         5'd15:   v = Z_W'(32);
         5'd16:   v = Z_W'(16);
         5'd17:   v = Z_W'(8);
         5'd18:   v = Z_W'(4);
         5'd19:   v = Z_W'(2);
         5'd20:   v = Z_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/ggvc_prerot.sv =====
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller: pre-rotation stage
// Form the goal offset, fold the left half-plane by pi and scale into Q.15.
// ----------------------------------------------------------------------------
module ggvc_prerot (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  logic                                   in_valid,
   input  logic signed [ggvc_pkg::POS_W-1:0]      pose_x,
   input  logic signed [ggvc_pkg::POS_W-1:0]      pose_y,
   input  logic signed [ggvc_pkg::HD_W-1:0]       heading,
   input  logic signed [ggvc_pkg::POS_W-1:0]      target_x,
   input  logic signed [ggvc_pkg::POS_W-1:0]      target_y,
   output ggvc_pkg::cordic_type                   q
);

   logic                       valid_ff;
   ggvc_pkg::cordic_type       data_ff;
   ggvc_pkg::cordic_type       data_in;
   logic signed [ggvc_pkg::POS_W:0] dx;
   logic signed [ggvc_pkg::POS_W:0] dy;
   logic signed [ggvc_pkg::POS_W:0] fx;
   logic signed [ggvc_pkg::POS_W:0] fy;

   always_comb begin
      dx = {target_x[ggvc_pkg::POS_W-1], target_x} - {pose_x[ggvc_pkg::POS_W-1], pose_x};
      dy = {target_y[ggvc_pkg::POS_W-1], target_y} - {pose_y[ggvc_pkg::POS_W-1], pose_y};
      fx = dx[ggvc_pkg::POS_W] ? -dx : dx;
      fy = dx[ggvc_pkg::POS_W] ? -dy : dy;
      data_in.valid = 1'b0;
      data_in.x     = ggvc_pkg::XY_W'(fx) <<< 4;
      data_in.y     = ggvc_pkg::XY_W'(fy) <<< 4;
      if (!dx[ggvc_pkg::POS_W]) begin
         data_in.z = '0;
      end else if (!dy[ggvc_pkg::POS_W]) begin
         data_in.z = ggvc_pkg::PI_Q20;
      end else begin
         data_in.z = -ggvc_pkg::PI_Q20;
      end
      data_in.hd = heading;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      q       = data_ff;
      q.valid = valid_ff;
   end

endmodule

// ===== rtl/ggvc_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller: CORDIC vectoring cell
// One micro-rotation toward the x axis, registered for the next cell.
// ----------------------------------------------------------------------------
module ggvc_cordic_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic [ggvc_pkg::IDX_W-1:0]         stage_idx,
   input  ggvc_pkg::cordic_type               d,
   output ggvc_pkg::cordic_type               q
);

   logic                           valid_ff;
   ggvc_pkg::cordic_type           data_ff;
   ggvc_pkg::cordic_type           data_in;
   logic signed [ggvc_pkg::XY_W-1:0] xs;
   logic signed [ggvc_pkg::XY_W-1:0] ys;
   logic signed [ggvc_pkg::Z_W-1:0]  ang;

   always_comb begin
      xs      = d.x >>> stage_idx;
      ys      = d.y >>> stage_idx;
      ang     = ggvc_pkg::atan_q20(stage_idx);
      data_in = d;
      // y at or above zero: rotate clockwise
      if (!d.y[ggvc_pkg::XY_W-1]) begin
         data_in.x = d.x + ys;
         data_in.y = d.y - xs;
         data_in.z = d.z + ang;
      end else begin
         data_in.x = d.x - ys;
         data_in.y = d.y + xs;
         data_in.z = d.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= d.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      q       = data_ff;
      q.valid = valid_ff;
   end

endmodule

// ===== rtl/ggvc_post.sv =====
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller: distance scaling and command selection
// Three stages: scale and error, threshold and gain, clamp and select.
// ----------------------------------------------------------------------------
module ggvc_post (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  ggvc_pkg::cordic_type               d,
   input  ggvc_pkg::cfg_type                  cfg,
   output logic                               out_valid,
   output logic [ggvc_pkg::VAL_W-1:0]         lin_cmd,
   output logic [ggvc_pkg::VAL_W-1:0]         ang_cmd
);

   // stage A
   logic                            a_valid_ff;
   logic [ggvc_pkg::KP_W-1:0]       a_prod_ff;
   logic [ggvc_pkg::KP_W-1:0]       a_prod_in;
   logic [ggvc_pkg::VAL_W-1:0]      a_aerr_ff;
   logic [ggvc_pkg::VAL_W-1:0]      a_aerr_in;
   logic [ggvc_pkg::MAG_W-1:0]      xmag;
   logic signed [ggvc_pkg::ERR_W-1:0] err;
   logic [ggvc_pkg::ERR_W-1:0]      err_abs;
   logic [ggvc_pkg::ERR_W-1:0]      err_rnd;

   // stage B
   logic                            b_valid_ff;
   logic                            b_stop_ff;
   logic                            b_stop_in;
   logic                            b_turn_ff;
   logic                            b_turn_in;
   logic [ggvc_pkg::VAL_W-1:0]      b_aerr_ff;
   logic [ggvc_pkg::GP_W-1:0]       b_prod_ff;
   logic [ggvc_pkg::GP_W-1:0]       b_prod_in;
   logic [ggvc_pkg::KP_W-1:0]       dist_rnd;
   logic [ggvc_pkg::DIST_W-1:0]     dist_q;

   // stage C
   logic                            c_valid_ff;
   logic [ggvc_pkg::VAL_W-1:0]      c_lin_ff;
   logic [ggvc_pkg::VAL_W-1:0]      c_lin_in;
   logic [ggvc_pkg::VAL_W-1:0]      c_ang_ff;
   logic [ggvc_pkg::VAL_W-1:0]      c_ang_in;
   logic [ggvc_pkg::GP_W:0]         lin_rnd;
   logic [ggvc_pkg::GP_W-11:0]      lin_full;
   logic [ggvc_pkg::VAL_W-1:0]      lin_sat;

   always_comb begin
      xmag      = d.x[ggvc_pkg::XY_W-1] ? '0 : d.x[ggvc_pkg::MAG_W-1:0];
      a_prod_in = ggvc_pkg::KP_W'(xmag) * ggvc_pkg::KP_W'(ggvc_pkg::INV_K_Q16);
      err       = ggvc_pkg::ERR_W'(d.z) - (ggvc_pkg::ERR_W'(d.hd) <<< 9);
      err_abs   = err[ggvc_pkg::ERR_W-1] ? ggvc_pkg::ERR_W'(-err) : ggvc_pkg::ERR_W'(err);
      err_rnd   = err_abs + ggvc_pkg::ERR_W'(256);
      a_aerr_in = err_rnd[9 +: ggvc_pkg::VAL_W];
   end

   always_comb begin
      dist_rnd  = a_prod_ff + (ggvc_pkg::KP_W'(1) << 19);
      dist_q    = dist_rnd[20 +: ggvc_pkg::DIST_W];
      b_stop_in = dist_q <= ggvc_pkg::DIST_W'(cfg.dist_thr);
      b_turn_in = a_aerr_ff > cfg.ang_thr;
      b_prod_in = ggvc_pkg::GP_W'(cfg.gain) * ggvc_pkg::GP_W'(dist_q);
   end

   always_comb begin
      lin_rnd  = {1'b0, b_prod_ff} + (ggvc_pkg::GP_W+1)'(1024);
      lin_full = lin_rnd[ggvc_pkg::GP_W:11];
      lin_sat  = (lin_full > (ggvc_pkg::GP_W-10)'(cfg.max_speed)) ? cfg.max_speed
                                                                  : lin_full[ggvc_pkg::VAL_W-1:0];
      if (b_stop_ff) begin
         c_lin_in = '0;
         c_ang_in = '0;
      end else if (b_turn_ff) begin
         c_lin_in = '0;
         c_ang_in = b_aerr_ff;
      end else begin
         c_lin_in = lin_sat;
         c_ang_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= d.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_prod_ff <= a_prod_in;
         a_aerr_ff <= a_aerr_in;
         b_stop_ff <= b_stop_in;
         b_turn_ff <= b_turn_in;
         b_aerr_ff <= a_aerr_ff;
         b_prod_ff <= b_prod_in;
         c_lin_ff  <= c_lin_in;
         c_ang_ff  <= c_ang_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign lin_cmd   = c_lin_ff;
   assign ang_cmd   = c_ang_ff;

endmodule

// ===== rtl/go_to_goal_velocity_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller
// Pose in, proportional drive or turn command out, via a vectoring CORDIC.
// ----------------------------------------------------------------------------
// One pose transfer is taken per clock cycle while the pipeline advances, and
// one command transfer comes out per pose, in order. The pipeline has one
// pre-rotation stage, one cell per micro-rotation (fourteen CORDIC cells) and
// three stages for the 1/K scaling, the gain multiply and the final clamp.
// The pipeline advances as one, holding only while the command register is
// full and the downstream side is not ready; sustained rate is one transfer
// per cycle. Configuration must be written through the csr_ port only while
// the block is idle, not enforced by the block; it then takes effect on the next pose.
// ----------------------------------------------------------------------------
`include "go_to_goal_velocity_controller_unit_defines.svh"

module go_to_goal_velocity_controller_unit (
   input  logic                              clock,
   input  logic                              reset,
   // pose channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [47:0]                       req_tdata,  // x position, y position, heading, pad
   // command channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // linear speed, turn rate, pad
   // configuration
   input  logic                              csr_we,
   input  logic [ggvc_pkg::CSR_W-1:0]        csr_addr,
   input  logic [ggvc_pkg::POS_W-1:0]        csr_wdata
);

   logic                                  adv;
   logic signed [ggvc_pkg::POS_W-1:0]     target_x_ff;
   logic signed [ggvc_pkg::POS_W-1:0]     target_y_ff;
   ggvc_pkg::cfg_type                     cfg_ff;
   ggvc_pkg::cordic_type                  chain [ggvc_pkg::NUM_CELLS+1];
   logic [ggvc_pkg::VAL_W-1:0]            lin_cmd;
   logic [ggvc_pkg::VAL_W-1:0]            ang_cmd;

   // Advance everything unless a finished command is held by the consumer
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Configuration registers; out-of-range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff      <= ggvc_pkg::RST_TARGET_X;
         target_y_ff      <= ggvc_pkg::RST_TARGET_Y;
         cfg_ff.gain      <= ggvc_pkg::RST_GAIN;
         cfg_ff.max_speed <= ggvc_pkg::RST_MAX_SPEED;
         cfg_ff.dist_thr  <= ggvc_pkg::RST_DIST_THR;
         cfg_ff.ang_thr   <= ggvc_pkg::RST_ANG_THR;
      end else if (csr_we) begin
         case (csr_addr)
            ggvc_pkg::CSR_TARGET_X:  target_x_ff      <= csr_wdata;
            ggvc_pkg::CSR_TARGET_Y:  target_y_ff      <= csr_wdata;
            ggvc_pkg::CSR_GAIN:      cfg_ff.gain      <= csr_wdata[ggvc_pkg::VAL_W-1:0];
            ggvc_pkg::CSR_MAX_SPEED: cfg_ff.max_speed <= csr_wdata[ggvc_pkg::VAL_W-1:0];
            ggvc_pkg::CSR_DIST_THR:  cfg_ff.dist_thr  <= csr_wdata[ggvc_pkg::VAL_W-1:0];
            ggvc_pkg::CSR_ANG_THR:   cfg_ff.ang_thr   <= csr_wdata[ggvc_pkg::VAL_W-1:0];
            default: ;
         endcase
      end
   end

   // Offset and half-plane fold
   ggvc_prerot u_prerot (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .pose_x    (req_tdata[15:0]),
      .pose_y    (req_tdata[31:16]),
      .heading   (req_tdata[45:32]),
      .target_x  (target_x_ff),
      .target_y  (target_y_ff),
      .q         (chain[0])
   );

   // Row of micro-rotation cells, each one stage of the vectoring CORDIC
   for (genvar g = 0; g < ggvc_pkg::NUM_CELLS; g++) begin : g_cell
      ggvc_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .stage_idx (ggvc_pkg::IDX_W'(g)),
         .d         (chain[g]),
         .q         (chain[g+1])
      );
   end

   // Scale, threshold and select; holds the command register
   ggvc_post u_post (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .d         (chain[ggvc_pkg::NUM_CELLS]),
      .cfg       (cfg_ff),
      .out_valid (rsp_tvalid),
      .lin_cmd   (lin_cmd),
      .ang_cmd   (ang_cmd)
   );

   assign rsp_tdata = {2'b00, ang_cmd, lin_cmd};

   // At most one of the two commands is ever non-zero
   `GGVC_ASSERT_NOW(a_one_command, rsp_tvalid, ~|lin_cmd || ~|ang_cmd, "both commands set")
   // A held command stalls the pose side
   `GGVC_ASSERT_NOW(a_stall_input, rsp_tvalid && !rsp_tready, !req_tready, "pose taken in stall")
   // Absolute angle error stays below 2^14 in Q4.11
   `GGVC_ASSERT_NOW(a_ang_range, rsp_tvalid, !ang_cmd[ggvc_pkg::VAL_W-1], "angle out of range")
   // A command the consumer did not take stays valid
   `GGVC_ASSERT_NEXT(a_hold_valid, rsp_tvalid && !rsp_tready, rsp_tvalid, "command dropped")

endmodule
